>>> rtl/hsvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_pkg
// shared types, constants and helpers of the rgb/hsv pixel converter
// ----------------------------------------------------------------------------
package hsvc_pkg;

   localparam int CH_W         = 8;
   localparam int NUM_W        = 16;
   localparam int DIV_STEPS    = NUM_W;
   localparam int FRONT_STAGES = 5;
   localparam int BACK_STAGES  = 2;
   localparam int LATENCY      = FRONT_STAGES + DIV_STEPS + BACK_STAGES;

   localparam logic [7:0]  CH_MAX       = 8'd255;
   localparam logic [10:0] DEG_GREEN    = 11'd120;
   localparam logic [10:0] DEG_BLUE     = 11'd240;
   localparam logic [10:0] DEG_FULL     = 11'd360;
   localparam logic [16:0] HUE_RECIP    = 17'd93207;
   localparam int          HUE_RECIP_SH = 25;

   localparam logic FUNC_TO_HSV = 1'b0;
   localparam logic FUNC_TO_RGB = 1'b1;

   typedef enum logic [1:0] {
      HUE_BASE_RED,
      HUE_BASE_GREEN,
      HUE_BASE_BLUE
   } hue_base_type;

   typedef struct packed {
      logic       func;
      logic [7:0] first_component;
      logic [7:0] second_component;
      logic [7:0] third_component;
   } req_type;

   typedef struct packed {
      logic [7:0] out_first;
      logic [7:0] out_second;
      logic [7:0] out_third;
   } rsp_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [CH_W-1:0]  rem;
      logic [NUM_W-1:0] quot;
      logic [CH_W-1:0]  den;
   } div_lane_type;

   typedef struct packed {
      logic         valid;
      logic         func;
      hue_base_type base;
      logic         neg;
      logic         hue_zero;
      logic         sat_zero;
      logic [7:0]   mx;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
      div_lane_type hue_lane;
      div_lane_type sat_lane;
   } cell_data_type;

   // exact x / 255 for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] s;
      s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
      return s[15:8];
   endfunction

endpackage

>>> rtl/hsvc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_front
// channel sort, sector split and the hsv to rgb products ahead of the divider
// ----------------------------------------------------------------------------
module hsvc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  hsvc_pkg::req_type      in_data,
   output hsvc_pkg::cell_data_type out_data
);
   import hsvc_pkg::*;

   typedef struct packed {
      logic         valid;
      logic         func;
      hue_base_type base;
      logic         neg;
      logic [7:0]   hue_abs;
      logic [7:0]   diff;
      logic [7:0]   mx;
      logic [2:0]   region;
      logic [7:0]   rem;
      logic [7:0]   sat;
      logic [7:0]   val;
   } s1_type;

   typedef struct packed {
      logic         valid;
      logic         func;
      hue_base_type base;
      logic         neg;
      logic [15:0]  hue_num;
      logic [15:0]  sat_num;
      logic [7:0]   diff;
      logic [7:0]   mx;
      logic [2:0]   region;
      logic [15:0]  x1;
      logic [15:0]  x2;
      logic [15:0]  pn;
      logic [7:0]   val;
   } s2_type;

   typedef struct packed {
      logic         valid;
      logic         func;
      hue_base_type base;
      logic         neg;
      logic [15:0]  hue_num;
      logic [15:0]  sat_num;
      logic [7:0]   diff;
      logic [7:0]   mx;
      logic [2:0]   region;
      logic [7:0]   qa;
      logic [7:0]   ta;
      logic [7:0]   p;
      logic [7:0]   val;
   } s3_type;

   typedef struct packed {
      logic         valid;
      logic         func;
      hue_base_type base;
      logic         neg;
      logic [15:0]  hue_num;
      logic [15:0]  sat_num;
      logic [7:0]   diff;
      logic [7:0]   mx;
      logic [2:0]   region;
      logic [15:0]  qn;
      logic [15:0]  tn;
      logic [7:0]   p;
      logic [7:0]   val;
   } s4_type;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   cell_data_type s5_ff, s5_in;

   // stage 1: max, min, hue branch, sector
   always_comb begin
      logic [7:0]        r, g, b, mx, mn;
      logic signed [8:0] dlt;
      logic [8:0]        dabs;
      logic [10:0]       h6, r255;
      logic [2:0]        region;
      r = in_data.first_component;
      g = in_data.second_component;
      b = in_data.third_component;
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      s1_in = '0;
      if (mx == r) begin
         s1_in.base = HUE_BASE_RED;
         dlt = $signed({1'b0, g}) - $signed({1'b0, b});
      end else if (mx == g) begin
         s1_in.base = HUE_BASE_GREEN;
         dlt = $signed({1'b0, b}) - $signed({1'b0, r});
      end else begin
         s1_in.base = HUE_BASE_BLUE;
         dlt = $signed({1'b0, r}) - $signed({1'b0, g});
      end
      dabs = dlt[8] ? 9'(-dlt) : 9'(dlt);
      h6 = ({3'b0, r} << 2) + ({3'b0, r} << 1);
      region = '0;
      for (int k = 1; k <= 6; k++) begin
         if (h6 >= 11'(k * 255)) region = region + 3'd1;
      end
      r255 = {region, 8'b0} - {8'b0, region};
      s1_in.valid   = in_valid;
      s1_in.func    = in_data.func;
      s1_in.neg     = dlt[8];
      s1_in.hue_abs = dabs[7:0];
      s1_in.diff    = mx - mn;
      s1_in.mx      = mx;
      s1_in.region  = region;
      s1_in.rem     = 8'(h6 - r255);
      s1_in.sat     = g;
      s1_in.val     = b;
   end

   // stage 2: numerators and first products
   always_comb begin
      s2_in.valid   = s1_ff.valid;
      s2_in.func    = s1_ff.func;
      s2_in.base    = s1_ff.base;
      s2_in.neg     = s1_ff.neg;
      s2_in.hue_num = ({8'b0, s1_ff.hue_abs} << 6) - ({8'b0, s1_ff.hue_abs} << 2);
      s2_in.sat_num = {s1_ff.diff, 8'b0} - {8'b0, s1_ff.diff};
      s2_in.diff    = s1_ff.diff;
      s2_in.mx      = s1_ff.mx;
      s2_in.region  = s1_ff.region;
      s2_in.x1      = s1_ff.sat * s1_ff.rem;
      s2_in.x2      = s1_ff.sat * (CH_MAX - s1_ff.rem);
      s2_in.pn      = s1_ff.val * (CH_MAX - s1_ff.sat);
      s2_in.val     = s1_ff.val;
   end

   // stage 3: first scaling by 1/255
   always_comb begin
      s3_in.valid   = s2_ff.valid;
      s3_in.func    = s2_ff.func;
      s3_in.base    = s2_ff.base;
      s3_in.neg     = s2_ff.neg;
      s3_in.hue_num = s2_ff.hue_num;
      s3_in.sat_num = s2_ff.sat_num;
      s3_in.diff    = s2_ff.diff;
      s3_in.mx      = s2_ff.mx;
      s3_in.region  = s2_ff.region;
      s3_in.qa      = div255(s2_ff.x1);
      s3_in.ta      = div255(s2_ff.x2);
      s3_in.p       = div255(s2_ff.pn);
      s3_in.val     = s2_ff.val;
   end

   // stage 4: second products
   always_comb begin
      s4_in.valid   = s3_ff.valid;
      s4_in.func    = s3_ff.func;
      s4_in.base    = s3_ff.base;
      s4_in.neg     = s3_ff.neg;
      s4_in.hue_num = s3_ff.hue_num;
      s4_in.sat_num = s3_ff.sat_num;
      s4_in.diff    = s3_ff.diff;
      s4_in.mx      = s3_ff.mx;
      s4_in.region  = s3_ff.region;
      s4_in.qn      = s3_ff.val * (CH_MAX - s3_ff.qa);
      s4_in.tn      = s3_ff.val * (CH_MAX - s3_ff.ta);
      s4_in.p       = s3_ff.p;
      s4_in.val     = s3_ff.val;
   end

   // stage 5: sector select and divider load
   always_comb begin
      logic [7:0] q, t, v, p;
      q = div255(s4_ff.qn);
      t = div255(s4_ff.tn);
      v = s4_ff.val;
      p = s4_ff.p;
      s5_in = '0;
      case (s4_ff.region)
         3'd0:    begin s5_in.red = v; s5_in.green = t; s5_in.blue = p; end
         3'd1:    begin s5_in.red = q; s5_in.green = v; s5_in.blue = p; end
         3'd2:    begin s5_in.red = p; s5_in.green = v; s5_in.blue = t; end
         3'd3:    begin s5_in.red = p; s5_in.green = q; s5_in.blue = v; end
         3'd4:    begin s5_in.red = t; s5_in.green = p; s5_in.blue = v; end
         default: begin s5_in.red = v; s5_in.green = p; s5_in.blue = q; end
      endcase
      s5_in.valid         = s4_ff.valid;
      s5_in.func          = s4_ff.func;
      s5_in.base          = s4_ff.base;
      s5_in.neg           = s4_ff.neg;
      s5_in.hue_zero      = (s4_ff.diff == 8'd0);
      s5_in.sat_zero      = (s4_ff.mx == 8'd0);
      s5_in.mx            = s4_ff.mx;
      s5_in.hue_lane.num  = s4_ff.hue_num;
      s5_in.hue_lane.den  = s4_ff.diff;
      s5_in.sat_lane.num  = s4_ff.sat_num;
      s5_in.sat_lane.den  = s4_ff.mx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
         s4_ff <= '0;
         s5_ff <= '0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
      end
   end

   assign out_data = s5_ff;

endmodule

>>> rtl/hsvc_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_div_cell
// one restoring step of the hue and saturation divides, registered
// ----------------------------------------------------------------------------
module hsvc_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  hsvc_pkg::cell_data_type in_data,
   output hsvc_pkg::cell_data_type out_data
);
   import hsvc_pkg::*;

   cell_data_type cell_ff, cell_in;

   function automatic div_lane_type step(input div_lane_type l);
      div_lane_type o;
      logic [CH_W:0] trial;
      logic          take;
      trial  = {l.rem, l.num[NUM_W-1]};
      take   = (trial >= {1'b0, l.den});
      o.num  = {l.num[NUM_W-2:0], 1'b0};
      o.rem  = take ? CH_W'(trial - {1'b0, l.den}) : trial[CH_W-1:0];
      o.quot = {l.quot[NUM_W-2:0], take};
      o.den  = l.den;
      return o;
   endfunction

   always_comb begin
      cell_in          = in_data;
      cell_in.hue_lane = step(in_data.hue_lane);
      cell_in.sat_lane = step(in_data.sat_lane);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign out_data = cell_ff;

endmodule

>>> rtl/hsvc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_back
// hue offset and wrap, scaling to 0..255 and result beat
// ----------------------------------------------------------------------------
module hsvc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  hsvc_pkg::cell_data_type in_data,
   output logic                    out_valid,
   output hsvc_pkg::rsp_type       out_data
);
   import hsvc_pkg::*;

   typedef struct packed {
      logic        valid;
      logic        func;
      logic [7:0]  sat;
      logic [7:0]  mx;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [16:0] scaled;
   } b1_type;

   b1_type  b1_ff, b1_in;
   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      logic signed [10:0] hq, ofs, d;
      logic [8:0]         d9;
      hq = $signed({3'b0, in_data.hue_lane.quot[7:0]});
      case (in_data.base)
         HUE_BASE_GREEN: ofs = $signed(DEG_GREEN);
         HUE_BASE_BLUE:  ofs = $signed(DEG_BLUE);
         default:        ofs = '0;
      endcase
      d = in_data.neg ? (ofs - hq) : (ofs + hq);
      if (in_data.hue_zero) d = '0;
      if (d < 0) d = d + $signed(DEG_FULL);
      d9 = d[8:0];
      b1_in.valid  = in_data.valid;
      b1_in.func   = in_data.func;
      b1_in.sat    = in_data.sat_zero ? 8'd0 : in_data.sat_lane.quot[7:0];
      b1_in.mx     = in_data.mx;
      b1_in.red    = in_data.red;
      b1_in.green  = in_data.green;
      b1_in.blue   = in_data.blue;
      b1_in.scaled = {d9, 8'b0} - {8'b0, d9};
   end

   always_comb begin
      logic [33:0] prod;
      prod     = b1_ff.scaled * HUE_RECIP;
      valid_in = b1_ff.valid;
      if (b1_ff.func == FUNC_TO_RGB) begin
         data_in.out_first  = b1_ff.red;
         data_in.out_second = b1_ff.green;
         data_in.out_third  = b1_ff.blue;
      end else begin
         data_in.out_first  = prod[HUE_RECIP_SH +: 8];
         data_in.out_second = b1_ff.sat;
         data_in.out_third  = b1_ff.mx;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         b1_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         b1_ff    <= b1_in;
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/rgb_hsv_pixel_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_hsv_pixel_converter_core
// stages from start to rsp_valid: 5 front, 16 divide cells, 2 back
// throughput: one beat per cycle, busy stays low; the divide chain is fully
// pipelined, one quotient bit per cell
// reset clears every valid flag and drops beats in flight; rsp is a strobe
// ----------------------------------------------------------------------------
module rgb_hsv_pixel_converter_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  hsvc_pkg::req_type req_data,
   output logic              rsp_valid,
   output hsvc_pkg::rsp_type rsp_data
);
   import hsvc_pkg::*;

   cell_data_type chain [DIV_STEPS+1];

   assign busy = 1'b0;

   hsvc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .in_data  (req_data),
      .out_data (chain[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      hsvc_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_data  (chain[i]),
         .out_data (chain[i+1])
      );
   end

   hsvc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_data   (chain[DIV_STEPS]),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

>>> rtl/hsvc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_checker
// port level checks of the pixel converter timing and grey handling
// ----------------------------------------------------------------------------
module hsvc_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input hsvc_pkg::req_type req_data,
   input logic              rsp_valid,
   input hsvc_pkg::rsp_type rsp_data
);
   import hsvc_pkg::*;

   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted beat without result");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##LATENCY !rsp_valid)
      else $error("result without accepted beat");

   a_grey_hsv: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.func == FUNC_TO_HSV &&
       req_data.first_component == req_data.second_component &&
       req_data.second_component == req_data.third_component)
      |-> ##LATENCY (rsp_data.out_first == 8'd0 && rsp_data.out_second == 8'd0 &&
                     rsp_data.out_third == $past(req_data.first_component, LATENCY)))
      else $error("grey pixel gave wrong hsv");

   a_grey_rgb: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.func == FUNC_TO_RGB && req_data.second_component == 8'd0)
      |-> ##LATENCY (rsp_data.out_first == $past(req_data.third_component, LATENCY) &&
                     rsp_data.out_second == $past(req_data.third_component, LATENCY) &&
                     rsp_data.out_third == $past(req_data.third_component, LATENCY)))
      else $error("zero saturation gave wrong rgb");

endmodule

bind rgb_hsv_pixel_converter_core hsvc_checker u_hsvc_checker (.*);
